[hw/rtl/pge_pkg.sv]
// ----------------------------------------------------------------------------
// Pitch glide envelope unit package
// Shared codes, tone tables and the note-to-octave split table.
// ----------------------------------------------------------------------------
package pge_pkg;

    // Default depth of the envelope table.
    localparam int ENV_ENTRIES_DEF = 256;

    // Reset value of the held note target.
    localparam logic [15:0] TARGET_RESET = 16'hffff;

    // Envelope commands from this value up to 0x7fff jump to another entry.
    localparam logic [15:0] JUMP_MARK = 16'h7f00;

    // The envelope timer stops counting at this value.
    localparam logic [7:0] TIMER_CAP = 8'hfe;

    // Semitones in one octave.
    localparam int NOTES_PER_OCTAVE = 12;

    // Input word kinds.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_NOTE  = 2'd1,
        ACT_TABLE = 2'd2
    } action_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GLIDE_SPEED = 2'd0,
        CFG_TRANSPOSE   = 2'd1,
        CFG_ENV_ENABLE  = 2'd2
    } cfg_index_t;

    // One octave of tone values plus the first note of the next octave.
    typedef logic [10:0] step_tbl_t [13];

    localparam step_tbl_t FM_STEPS = '{
        11'd644, 11'd681, 11'd722, 11'd765, 11'd810, 11'd858, 11'd910,
        11'd964, 11'd1021, 11'd1081, 11'd1146, 11'd1214, 11'd1288
    };

    localparam step_tbl_t PSG_STEPS = '{
        11'd1710, 11'd1614, 11'd1524, 11'd1438, 11'd1357, 11'd1281, 11'd1209,
        11'd1141, 11'd1077, 11'd1017, 11'd960, 11'd906, 11'd855
    };

    // Each entry holds {octave[4:0], note in octave[3:0]} for a semitone number.
    typedef logic [8:0] note_split_tbl_t [256];

    function automatic note_split_tbl_t build_note_split();
        note_split_tbl_t tbl;
        logic [4:0]      oct;
        logic [3:0]      idx;
        oct = '0;
        idx = '0;
        for (int n = 0; n < 256; n++)
        begin
            tbl[n] = {oct, idx};
            if (idx == 4'(NOTES_PER_OCTAVE - 1))
            begin
                idx = '0;
                oct = oct + 5'd1;
            end
            else
            begin
                idx = idx + 4'd1;
            end
        end
        return tbl;
    endfunction

    localparam note_split_tbl_t NOTE_SPLIT = build_note_split();

endpackage

[hw/rtl/pge_freq_conv.sv]
// ----------------------------------------------------------------------------
// Pitch to tone converter
// Turns a pitch (semitone and detune) into the FM block/fnum word and the
// PSG period by interpolating between neighboring table notes.
// ----------------------------------------------------------------------------
module pge_freq_conv (
    input  logic [15:0] pitch,
    output logic [13:0] fm_word,
    output logic [10:0] psg_period
);
    import pge_pkg::*;

    logic [7:0]         note;
    logic [7:0]         det;
    logic [4:0]         oct;
    logic [3:0]         idx;
    logic [10:0]        fm_lo;
    logic [10:0]        fm_hi;
    logic [10:0]        psg_lo;
    logic [10:0]        psg_hi;
    logic signed [11:0] fm_span;
    logic signed [11:0] psg_span;
    logic signed [20:0] fm_prod;
    logic signed [20:0] psg_prod;
    logic signed [20:0] fm_adj;
    logic signed [20:0] psg_adj;
    logic [10:0]        fm_f;
    logic [10:0]        psg_f;

    // Split the semitone number into octave and note within the octave.
    assign note       = pitch[15:8];
    assign det        = pitch[7:0];
    assign {oct, idx} = NOTE_SPLIT[note];

    // Neighboring table values and their signed distance.
    assign fm_lo    = FM_STEPS[idx];
    assign fm_hi    = FM_STEPS[idx + 4'd1];
    assign psg_lo   = PSG_STEPS[idx];
    assign psg_hi   = PSG_STEPS[idx + 4'd1];
    assign fm_span  = $signed({1'b0, fm_hi}) - $signed({1'b0, fm_lo});
    assign psg_span = $signed({1'b0, psg_hi}) - $signed({1'b0, psg_lo});

    // Interpolate by the detune fraction, rounding toward minus infinity.
    assign fm_prod  = fm_span * $signed({1'b0, det});
    assign psg_prod = psg_span * $signed({1'b0, det});
    assign fm_adj   = fm_prod >>> 8;
    assign psg_adj  = psg_prod >>> 8;
    assign fm_f     = fm_lo + fm_adj[10:0];
    assign psg_f    = psg_lo + psg_adj[10:0];

    // Block number sits above the fnum; the PSG period halves per octave.
    assign fm_word    = {oct[2:0], fm_f};
    assign psg_period = oct[4] ? '0 : (psg_f >> oct[3:0]);

endmodule

[hw/rtl/pitch_glide_envelope_unit_top.sv]
// ----------------------------------------------------------------------------
// Pitch glide envelope unit
// One channel of pitch glide, transpose and table-driven pitch envelope.
// ----------------------------------------------------------------------------
// Note words and table words are taken one per cycle unless the update
// stage is blocked by the output, and give no result. A tick word reads
// the current and following envelope entries from the two read ports of
// the envelope memory into registers at the edge that accepts it; the
// update stage then updates glide and envelope state and loads the output
// register once the output is not stalled. A tick holds the update stage
// until its update lands, and the next tick is not taken before then, so
// the memory is never read ahead of that update. The envelope memory has
// no reset; every entry the envelope walk reaches must be written first.
module pitch_glide_envelope_unit_top #(
    parameter int ENV_ENTRIES = pge_pkg::ENV_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] target_pitch,
    input  logic [7:0]  entry_index,
    input  logic [31:0] entry_word,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pitch_value,
    output logic [13:0] fm_word,
    output logic [10:0] psg_period,
    output logic        pitch_changed,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pge_pkg::*;

    localparam int ADDR_W = (ENV_ENTRIES > 1) ? $clog2(ENV_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENV_ENTRIES - 1);

    // Maps any 8-bit entry number onto a memory address, wrapping at the depth.
    typedef logic [ADDR_W-1:0] wrap_tbl_t [256];

    function automatic wrap_tbl_t build_wrap();
        wrap_tbl_t         tbl;
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int n = 0; n < 256; n++)
        begin
            tbl[n] = r;
            if (r == LAST_ADDR)
            begin
                r = '0;
            end
            else
            begin
                r = r + ADDR_W'(1);
            end
        end
        return tbl;
    endfunction

    localparam wrap_tbl_t WRAP = build_wrap();

    // Configuration registers
    logic [7:0]        glide_speed_reg;
    logic [7:0]        transpose_reg;
    logic              env_enable_reg;

    // Channel state
    logic [15:0]       target_reg;
    logic [15:0]       target_next;
    logic [15:0]       glide_reg;
    logic [15:0]       glide_next;
    logic [7:0]        env_index_reg;
    logic [7:0]        env_index_next;
    logic [7:0]        env_timer_reg;
    logic [7:0]        env_timer_next;
    logic [15:0]       env_value_reg;
    logic [15:0]       env_value_next;
    logic              restart_reg;
    logic              restart_next;
    logic [15:0]       prev_pitch_reg;
    logic [15:0]       prev_pitch_next;

    // Pipeline control
    logic              b_valid_reg;
    logic              b_valid_next;
    logic              o_valid_reg;
    logic              o_valid_next;
    logic              b_adv;
    logic              in_fire;
    logic              tick_fire;
    logic              note_fire;
    logic              table_fire;

    // Envelope memory and its registered read data
    logic [31:0]       env_mem [ENV_ENTRIES];
    logic [31:0]       cur_word_reg;
    logic [31:0]       nxt_word_reg;
    logic [ADDR_W-1:0] rd_cur_addr;
    logic [ADDR_W-1:0] rd_nxt_addr;

    // Update stage signals
    logic [15:0]        diff;
    logic signed [15:0] diff_sh;
    logic signed [8:0]  step;
    logic signed [17:0] step_prod;
    logic signed [17:0] step_half;
    logic [15:0]        glide_sum;
    logic [15:0]        new_diff;
    logic [15:0]        glide_new;
    logic [15:0]        base_pitch;
    logic [7:0]         idx_eff;
    logic [7:0]         timer_eff;
    logic [15:0]        cur_cmd;
    logic [7:0]         cur_delta;
    logic [7:0]         cur_len;
    logic [15:0]        nxt_cmd;
    logic [15:0]        val_start;
    logic [15:0]        env_val_new;
    logic [7:0]         idx_new;
    logic [7:0]         timer_new;
    logic [15:0]        pitch_b;

    // Output register
    logic [15:0]        o_pitch_reg;
    logic               o_changed_reg;

    // ------------------------------------------------------------------
    // Handshake: a tick waits for the update stage to empty; other words
    // only wait while the update stage is blocked by the output.
    // ------------------------------------------------------------------
    assign b_adv    = b_valid_reg && (!o_valid_reg || !out_stall);
    assign in_stall = (action == ACT_TICK) ? b_valid_reg : (b_valid_reg && !b_adv);
    assign in_fire    = in_valid && !in_stall;
    assign tick_fire  = in_fire && (action == ACT_TICK);
    assign note_fire  = in_fire && (action == ACT_NOTE);
    assign table_fire = in_fire && (action == ACT_TABLE);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_speed_reg <= '0;
            transpose_reg   <= '0;
            env_enable_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GLIDE_SPEED: glide_speed_reg <= cfg_data;
                CFG_TRANSPOSE:   transpose_reg   <= cfg_data;
                CFG_ENV_ENABLE:  env_enable_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Envelope memory: one write port, two registered read ports.
    // ------------------------------------------------------------------
    assign rd_cur_addr = restart_reg ? '0 : WRAP[env_index_reg];
    assign rd_nxt_addr = (rd_cur_addr == LAST_ADDR) ? '0 : rd_cur_addr + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (table_fire)
        begin
            env_mem[WRAP[entry_index]] <= entry_word;
        end
        if (tick_fire)
        begin
            cur_word_reg <= env_mem[rd_cur_addr];
            nxt_word_reg <= env_mem[rd_nxt_addr];
        end
    end

    // ------------------------------------------------------------------
    // Glide: proportional step toward the target, clamped on overshoot; a glide speed of zero jumps to the target.
    // ------------------------------------------------------------------
    always_comb
    begin
        diff      = target_reg - glide_reg;
        diff_sh   = $signed(diff) >>> 8;
        step      = diff_sh[8:0] + (diff[15] ? -9'sd1 : 9'sd1);
        step_prod = step * $signed({1'b0, glide_speed_reg});
        step_half = step_prod >>> 1;
        glide_sum = glide_reg + step_half[15:0];
        new_diff  = target_reg - glide_sum;
        if ((glide_speed_reg == '0) || (new_diff[15] != diff[15]))
        begin
            glide_new = target_reg;
        end
        else
        begin
            glide_new = glide_sum;
        end
        base_pitch = glide_new + {transpose_reg, 8'h00};
    end

    // ------------------------------------------------------------------
    // Envelope walk over the entries read for this tick.
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_eff   = restart_reg ? '0 : env_index_reg;
        timer_eff = restart_reg ? '0 : env_timer_reg;
        cur_cmd   = cur_word_reg[31:16];
        cur_delta = cur_word_reg[15:8];
        cur_len   = cur_word_reg[7:0];
        nxt_cmd   = nxt_word_reg[31:16];

        val_start   = (timer_eff == '0) ? cur_cmd : env_value_reg;
        env_val_new = val_start + {{8{cur_delta[7]}}, cur_delta};

        idx_new   = idx_eff;
        timer_new = timer_eff;
        if (timer_eff == cur_len)
        begin
            // The following entry either jumps or is simply the next one.
            if (nxt_cmd[15:8] == JUMP_MARK[15:8])
            begin
                idx_new = nxt_cmd[7:0];
            end
            else
            begin
                idx_new = idx_eff + 8'd1;
            end
            timer_new = '0;
        end
        else if (timer_eff < TIMER_CAP)
        begin
            timer_new = timer_eff + 8'd1;
        end

        pitch_b = env_enable_reg ? (base_pitch + env_val_new) : base_pitch;
    end

    // ------------------------------------------------------------------
    // Next state. A note accepted at the same edge as an update wins.
    // ------------------------------------------------------------------
    always_comb
    begin
        target_next     = note_fire ? target_pitch : target_reg;
        glide_next      = glide_reg;
        env_index_next  = env_index_reg;
        env_timer_next  = env_timer_reg;
        env_value_next  = env_value_reg;
        prev_pitch_next = prev_pitch_reg;
        restart_next    = restart_reg;

        if (b_adv)
        begin
            glide_next      = glide_new;
            prev_pitch_next = pitch_b;
            restart_next    = 1'b0;
            if (env_enable_reg)
            begin
                env_index_next = idx_new;
                env_timer_next = timer_new;
                env_value_next = env_val_new;
            end
        end
        if (note_fire)
        begin
            restart_next = 1'b1;
        end

        if (tick_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end

        if (b_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            o_valid_next = 1'b0;
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RESET;
            glide_reg      <= '0;
            env_index_reg  <= '0;
            env_timer_reg  <= '0;
            env_value_reg  <= '0;
            restart_reg    <= 1'b1;
            prev_pitch_reg <= '0;
            b_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            target_reg     <= target_next;
            glide_reg      <= glide_next;
            env_index_reg  <= env_index_next;
            env_timer_reg  <= env_timer_next;
            env_value_reg  <= env_value_next;
            restart_reg    <= restart_next;
            prev_pitch_reg <= prev_pitch_next;
            b_valid_reg    <= b_valid_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            o_pitch_reg   <= pitch_b;
            o_changed_reg <= (pitch_b != prev_pitch_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output word: tone values derive from the registered pitch.
    // ------------------------------------------------------------------
    pge_freq_conv u_freq_conv (
        .pitch      (o_pitch_reg),
        .fm_word    (fm_word),
        .psg_period (psg_period)
    );

    assign out_valid     = o_valid_reg;
    assign pitch_value   = o_pitch_reg;
    assign pitch_changed = o_changed_reg;

endmodule
